// ----- design/pist_pkg.sv -----
package pist_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int GUARD    = 24;
  localparam int CW       = DIFF_W + GUARD + 3;
  localparam int ZW       = 26;
  localparam int STEPS    = 20;
  localparam int SHIFT_W  = 5;
  localparam int FRAC     = 6;
  localparam int TAB_FRAC = 16;
  localparam int ROUND_SH = TAB_FRAC - FRAC;
  localparam int BEAR_W   = FRAC + 9;
  localparam int RW       = ZW - ROUND_SH;
  localparam int GAP_W    = BEAR_W + 1;
  localparam int RANGE_W  = 16;
  localparam int HALF_W   = 14;
  localparam int SQ_W     = 2 * RANGE_W;
  localparam int IN_W     = 6 * COORD_W;
  localparam int OUT_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [ZW-1:0] HALF_Z = ZW'(180 * (1 << TAB_FRAC));
  localparam logic signed [RW-1:0] LIM    = RW'(180 * (1 << FRAC));
  localparam logic [GAP_W-1:0]     LIM_G  = GAP_W'(180 * (1 << FRAC));
  localparam logic [GAP_W-1:0]     FULL_G = GAP_W'(360 * (1 << FRAC));

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ANGLE = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic valid;
    logic reach;
    vec_t tgt;
    vec_t aim;
  } cell_t;

  typedef struct packed {
    logic                     valid;
    logic                     reach;
    logic                     sector;
    logic signed [BEAR_W-1:0] bearing;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_c(input logic [SHIFT_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = ZW'(2949120);
      5'd1:  a = ZW'(1740967);
      5'd2:  a = ZW'(919879);
      5'd3:  a = ZW'(466945);
      5'd4:  a = ZW'(234379);
      5'd5:  a = ZW'(117304);
      5'd6:  a = ZW'(58666);
      5'd7:  a = ZW'(29335);
      5'd8:  a = ZW'(14668);
      5'd9:  a = ZW'(7334);
      5'd10: a = ZW'(3667);
      5'd11: a = ZW'(1833);
      5'd12: a = ZW'(917);
      5'd13: a = ZW'(458);
      5'd14: a = ZW'(229);
      5'd15: a = ZW'(115);
      5'd16: a = ZW'(57);
      5'd17: a = ZW'(29);
      5'd18: a = ZW'(14);
      5'd19: a = ZW'(7);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/pist_front.sv -----
module pist_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [pist_pkg::IN_W-1:0]           data_i,
  input  logic [pist_pkg::RANGE_W-1:0]        max_range_i,
  output pist_pkg::cell_t                     cell_o
);
  import pist_pkg::*;

  logic                     a_valid_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, ax_q, ay_q;

  logic                     b_valid_q;
  logic                     b_over_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q, maxsq_q;
  vec_t                     b_tgt_q, b_aim_q;
  vec_t                     b_tgt_d, b_aim_d;
  logic                     b_over_d;
  logic [DIFF_W-1:0]        adx, ady;

  logic                     c_valid_q;
  logic                     c_reach_q;
  vec_t                     c_tgt_q, c_aim_q;
  logic [SQ_W:0]            sum;

  function automatic logic signed [DIFF_W-1:0] sub_c(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic [DIFF_W-1:0] abs_c(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  // scale up and fold the left half-plane onto the right
  function automatic vec_t prerot(input logic signed [DIFF_W-1:0] dx,
                                  input logic signed [DIFF_W-1:0] dy);
    vec_t v;
    logic signed [CW-1:0] x, y;
    x = $signed({{(CW-DIFF_W-GUARD){dx[DIFF_W-1]}}, dx, {GUARD{1'b0}}});
    y = $signed({{(CW-DIFF_W-GUARD){dy[DIFF_W-1]}}, dy, {GUARD{1'b0}}});
    v.zero = (dx == '0) && (dy == '0);
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = (y >= 0) ? HALF_Z : -HALF_Z;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  assign adx      = abs_c(dx_q);
  assign ady      = abs_c(dy_q);
  assign b_over_d = (adx > DIFF_W'(max_range_i)) || (ady > DIFF_W'(max_range_i));
  assign b_tgt_d  = prerot(dx_q, dy_q);
  assign b_aim_d  = prerot(ax_q, ay_q);
  assign sum      = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= sub_c(data_i[2*COORD_W +: COORD_W], data_i[0 +: COORD_W]);
      dy_q <= sub_c(data_i[3*COORD_W +: COORD_W], data_i[COORD_W +: COORD_W]);
      ax_q <= sub_c(data_i[4*COORD_W +: COORD_W], data_i[0 +: COORD_W]);
      ay_q <= sub_c(data_i[5*COORD_W +: COORD_W], data_i[COORD_W +: COORD_W]);
      b_over_q <= b_over_d;
      sqx_q    <= adx[RANGE_W-1:0] * adx[RANGE_W-1:0];
      sqy_q    <= ady[RANGE_W-1:0] * ady[RANGE_W-1:0];
      maxsq_q  <= max_range_i * max_range_i;
      b_tgt_q  <= b_tgt_d;
      b_aim_q  <= b_aim_d;
      c_reach_q <= !b_over_q && (sum <= {1'b0, maxsq_q});
      c_tgt_q   <= b_tgt_q;
      c_aim_q   <= b_aim_q;
    end
  end

  assign cell_o = {c_valid_q, c_reach_q, c_tgt_q, c_aim_q};

endmodule

// ----- design/pist_cell.sv -----
module pist_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [pist_pkg::SHIFT_W-1:0]      shift_i,
  input  logic signed [pist_pkg::ZW-1:0]    angle_i,
  input  pist_pkg::cell_t                   cell_i,
  output pist_pkg::cell_t                   cell_o
);
  import pist_pkg::*;

  logic valid_q;
  logic reach_q;
  vec_t tgt_q, aim_q;

  // one vectoring step: rotate toward the x axis
  function automatic vec_t step(input vec_t v, input logic [SHIFT_W-1:0] sh,
                                input logic signed [ZW-1:0] ang);
    vec_t r;
    logic signed [CW-1:0] xs, ys;
    xs = v.x >>> sh;
    ys = v.y >>> sh;
    r.zero = v.zero;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ang;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ang;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reach_q <= cell_i.reach;
      tgt_q   <= step(cell_i.tgt, shift_i, angle_i);
      aim_q   <= step(cell_i.aim, shift_i, angle_i);
    end
  end

  assign cell_o = {valid_q, reach_q, tgt_q, aim_q};

endmodule

// ----- design/pist_back.sv -----
module pist_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  pist_pkg::cell_t                   cell_i,
  input  logic [pist_pkg::HALF_W-1:0]       half_angle_i,
  output pist_pkg::res_t                    res_o
);
  import pist_pkg::*;

  logic                     valid_q, reach_q;
  logic signed [BEAR_W-1:0] tb_q, ab_q;
  logic signed [BEAR_W:0]   diff;
  logic [GAP_W-1:0]         gap_abs, gap;

  // round half up to the output step, clamp to a half turn
  function automatic logic signed [BEAR_W-1:0] round_c(input vec_t v);
    logic signed [ZW-1:0] zs;
    logic signed [RW-1:0] r;
    zs = v.z + ZW'(1 << (ROUND_SH - 1));
    r  = zs[ZW-1:ROUND_SH];
    if (v.zero) begin
      r = '0;
    end else if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[BEAR_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reach_q <= cell_i.reach;
      tb_q    <= round_c(cell_i.tgt);
      ab_q    <= round_c(cell_i.aim);
    end
  end

  // wrap the bearing gap into a half turn
  assign diff    = {tb_q[BEAR_W-1], tb_q} - {ab_q[BEAR_W-1], ab_q};
  assign gap_abs = diff[BEAR_W] ? GAP_W'(-diff) : GAP_W'(diff);
  assign gap     = (gap_abs > LIM_G) ? FULL_G - gap_abs : gap_abs;

  assign res_o.valid   = valid_q;
  assign res_o.reach   = reach_q;
  assign res_o.sector  = reach_q && (gap < GAP_W'(half_angle_i));
  assign res_o.bearing = tb_q;

endmodule

// ----- design/point_in_sector_test_unit.sv -----
// Point-in-sector test unit.
// Input stream (s_*): one item holds origin, target and aim points, six
// signed 16-bit coordinates. Output stream (m_*): one result per item with
// within_reach, within_sector and the origin-to-target bearing in 1/64 deg.
// Config channel (cfg_*): index 0 writes max_range, index 1 writes
// half_angle; always ready, write only while no item is in flight.
// From input accept to output valid an item passes three front
// stages (differences, squares and half-plane fold, range compare), a row
// of 20 CORDIC cells that vector target and aim side by side, one rounding
// stage and output register. One item is taken per cycle unless stalled.
// The whole row advances together; when the output register holds an item
// the receiver has not taken, the row and s_tready_o stall and every item
// stays in place. Reset clears all valid bits and both config registers.
module point_in_sector_test_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // origin_x, origin_y, target_x, target_y, aim_x, aim_y
  input  logic [pist_pkg::IN_W-1:0]            s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // within_reach, within_sector, target_bearing[14:0], zero pad
  output logic [pist_pkg::OUT_W-1:0]           m_tdata_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pist_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pist_pkg::RANGE_W-1:0]         cfg_data_i
);
  import pist_pkg::*;

  logic [RANGE_W-1:0] max_range_q;
  logic [HALF_W-1:0]  half_angle_q;
  logic               en;
  cell_t              chain [STEPS+1];
  res_t               res;
  logic               out_valid_q;
  logic               reach_q, sector_q;
  logic signed [BEAR_W-1:0] bearing_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || m_tready_i;
  assign s_tready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q  <= '0;
      half_angle_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_RANGE:  max_range_q  <= cfg_data_i;
        REG_HALF_ANGLE: half_angle_q <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  pist_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_tvalid_i),
    .data_i     (s_tdata_i),
    .max_range_i(max_range_q),
    .cell_o     (chain[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    pist_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .shift_i(SHIFT_W'(i)),
      .angle_i(atan_c(SHIFT_W'(i))),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  pist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cell_i      (chain[STEPS]),
    .half_angle_i(half_angle_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      reach_q   <= res.reach;
      sector_q  <= res.sector;
      bearing_q <= res.bearing;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OUT_W-BEAR_W-2){1'b0}}, bearing_q, sector_q, reach_q};

  a_sector_needs_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sector_q |-> reach_q) else $error("sector without reach");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (bearing_q <= $signed(LIM[BEAR_W-1:0])) &&
                    (bearing_q >= -$signed(LIM[BEAR_W-1:0])))
    else $error("bearing out of range");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_tready_i |-> !s_tready_o) else $error("input taken during stall");

endmodule
